FILE: rtl/ptrm_pkg.sv
`default_nettype none
package ptrm_pkg;

   // Field widths
   localparam int CNT_W   = 32;
   localparam int ERR_W   = 16;
   localparam int RATE_W  = 16;
   localparam int SCALE_W = 14;
   localparam int PROD_W  = CNT_W + SCALE_W;

   // Rate arithmetic constants
   localparam logic [SCALE_W-1:0] RATE_SCALE = SCALE_W'(10000);
   localparam logic [RATE_W-1:0]  RATE_MAX   = 16'hFFFF;

   // Quotient bits produced by the serial divider, one per step
   localparam int QUO_BITS = RATE_W;
   localparam int STEP_W   = $clog2(QUO_BITS);

   typedef enum logic [1:0] {
      CMD_FWD    = 2'd0,
      CMD_FAIL   = 2'd1,
      CMD_SAMPLE = 2'd2
   } cmd_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic apply;
      logic diff;
      logic mul;
      logic sat;
      logic div_step;
      logic store;
      logic sel_phone;
      logic load_rsp;
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic sample_go;
   } ctl_sts_type;

endpackage
`default_nettype wire

FILE: rtl/ptrm_if.sv
`default_nettype none
interface ptrm_req_if
   import ptrm_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              command;
   logic                    to_car;
   logic signed [ERR_W-1:0] error_code;
   logic [CNT_W-1:0]        now_ms;

   modport source (output valid, output command, output to_car, output error_code,
                   output now_ms, input ready);
   modport sink   (input valid, input command, input to_car, input error_code,
                   input now_ms, output ready);
endinterface

interface ptrm_rsp_if
   import ptrm_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [CNT_W-1:0]        car_total;
   logic [CNT_W-1:0]        phone_total;
   logic [RATE_W-1:0]       car_rate_tenths;
   logic [RATE_W-1:0]       phone_rate_tenths;
   logic signed [ERR_W-1:0] recent_error;
   logic [CNT_W-1:0]        repeat_count;

   modport source (output valid, output car_total, output phone_total,
                   output car_rate_tenths, output phone_rate_tenths,
                   output recent_error, output repeat_count, input ready);
   modport sink   (input valid, input car_total, input phone_total,
                   input car_rate_tenths, input phone_rate_tenths,
                   input recent_error, input repeat_count, output ready);
endinterface
`default_nettype wire

FILE: rtl/ptrm_ctrl.sv
`default_nettype none
module ptrm_ctrl
   import ptrm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   input  wire ctl_sts_type sts,
   output ctl_cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIFF,
      ST_MUL,
      ST_SAT,
      ST_DIV,
      ST_STORE,
      ST_DONE
   } state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic              phone_ff;
   logic              rsp_valid_ff;

   // Decode commands from the current state
   always_comb begin
      cmd           = '0;
      cmd.capture   = (state_ff == ST_IDLE) && req_valid;
      cmd.apply     = (state_ff == ST_EXEC);
      cmd.diff      = (state_ff == ST_DIFF);
      cmd.mul       = (state_ff == ST_MUL);
      cmd.sat       = (state_ff == ST_SAT);
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.store     = (state_ff == ST_STORE);
      cmd.sel_phone = phone_ff;
      cmd.load_rsp  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequence one event: car pass then phone pass for a rate sample
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         phone_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               phone_ff <= 1'b0;
               state_ff <= sts.sample_go ? ST_DIFF : ST_DONE;
            end
            ST_DIFF: state_ff <= ST_MUL;
            ST_MUL:  state_ff <= ST_SAT;
            ST_SAT:  state_ff <= ST_DIV;
            ST_DIV: begin
               if (step_ff == STEP_W'(QUO_BITS - 1)) begin
                  step_ff  <= '0;
                  state_ff <= ST_STORE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_STORE: begin
               if (phone_ff) begin
                  state_ff <= ST_DONE;
               end else begin
                  phone_ff <= 1'b1;
                  state_ff <= ST_DIFF;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_accept_drops_ready: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after an input transfer");

   a_step_only_in_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DIV) |-> (step_ff == '0))
      else $error("divider step count nonzero outside division");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");

   a_both_passes: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && $past(state_ff == ST_STORE)) |-> $past(phone_ff))
      else $error("rate sample finished without the phone pass");
`endif

endmodule
`default_nettype wire

FILE: rtl/ptrm_dp.sv
`default_nettype none
module ptrm_dp
   import ptrm_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ctl_cmd_type             cmd,
   output ctl_sts_type                  sts,
   input  wire logic [1:0]              req_command,
   input  wire logic                    req_to_car,
   input  wire logic signed [ERR_W-1:0] req_error_code,
   input  wire logic [CNT_W-1:0]        req_now_ms,
   output logic [CNT_W-1:0]             rsp_car_total,
   output logic [CNT_W-1:0]             rsp_phone_total,
   output logic [RATE_W-1:0]            rsp_car_rate_tenths,
   output logic [RATE_W-1:0]            rsp_phone_rate_tenths,
   output logic signed [ERR_W-1:0]      rsp_recent_error,
   output logic [CNT_W-1:0]             rsp_repeat_count
);

   // Captured event
   logic [1:0]              command_ff;
   logic                    to_car_ff;
   logic signed [ERR_W-1:0] error_code_ff;
   logic [CNT_W-1:0]        now_ms_ff;

   // Statistics state
   logic [CNT_W-1:0]        car_count_ff;
   logic [CNT_W-1:0]        phone_count_ff;
   logic [CNT_W-1:0]        car_mark_ff;
   logic [CNT_W-1:0]        phone_mark_ff;
   logic [CNT_W-1:0]        time_mark_ff;
   logic [RATE_W-1:0]       car_rate_ff;
   logic [RATE_W-1:0]       phone_rate_ff;
   logic signed [ERR_W-1:0] last_error_ff;
   logic [CNT_W-1:0]        error_repeats_ff;

   // Rate computation
   logic [CNT_W-1:0]        elapsed_ff;
   logic [CNT_W-1:0]        packets_ff;
   logic [PROD_W-1:0]       product_ff;
   logic                    sat_ff;
   logic [CNT_W-1:0]        rem_ff;
   logic [QUO_BITS-1:0]     low_ff;
   logic [QUO_BITS-1:0]     quo_ff;

   logic [CNT_W-1:0]        elapsed_in;
   logic [CNT_W:0]          rem_shift;
   logic                    quo_bit;
   logic [RATE_W-1:0]       rate_in;

   assign elapsed_in    = now_ms_ff - time_mark_ff;
   assign sts.sample_go = (command_ff == CMD_SAMPLE) && (elapsed_in != '0);

   // Restoring divide step: shift in next dividend bit, subtract if it fits
   assign rem_shift = {rem_ff, low_ff[QUO_BITS-1]};
   assign quo_bit   = (rem_shift >= {1'b0, elapsed_ff});
   assign rate_in   = sat_ff ? RATE_MAX : quo_ff;

   // Capture the event on transfer
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         command_ff    <= req_command;
         to_car_ff     <= req_to_car;
         error_code_ff <= req_error_code;
         now_ms_ff     <= req_now_ms;
      end
   end

   // Statistics registers
   always_ff @(posedge clock) begin
      if (reset) begin
         car_count_ff     <= '0;
         phone_count_ff   <= '0;
         car_mark_ff      <= '0;
         phone_mark_ff    <= '0;
         time_mark_ff     <= '0;
         car_rate_ff      <= '0;
         phone_rate_ff    <= '0;
         last_error_ff    <= '0;
         error_repeats_ff <= '0;
      end else begin
         if (cmd.apply) begin
            case (command_ff)
               CMD_FWD: begin
                  if (to_car_ff) car_count_ff <= car_count_ff + 1'b1;
                  else           phone_count_ff <= phone_count_ff + 1'b1;
               end
               CMD_FAIL: begin
                  if (error_code_ff == last_error_ff) begin
                     error_repeats_ff <= error_repeats_ff + 1'b1;
                  end else begin
                     last_error_ff    <= error_code_ff;
                     error_repeats_ff <= CNT_W'(1);
                  end
               end
               default: ;
            endcase
         end
         // Store rate; the phone pass also advances the marks
         if (cmd.store) begin
            if (cmd.sel_phone) begin
               phone_rate_ff <= rate_in;
               car_mark_ff   <= car_count_ff;
               phone_mark_ff <= phone_count_ff;
               time_mark_ff  <= now_ms_ff;
            end else begin
               car_rate_ff <= rate_in;
            end
         end
      end
   end

   // Elapsed time, packet difference, multiply, saturation check and serial divide
   always_ff @(posedge clock) begin
      if (cmd.apply) elapsed_ff <= elapsed_in;
      if (cmd.diff) begin
         packets_ff <= cmd.sel_phone ? (phone_count_ff - phone_mark_ff)
                                     : (car_count_ff - car_mark_ff);
      end
      if (cmd.mul) product_ff <= {{SCALE_W{1'b0}}, packets_ff} * {{CNT_W{1'b0}}, RATE_SCALE};
      if (cmd.sat) begin
         sat_ff <= ({{(CNT_W + QUO_BITS - PROD_W){1'b0}}, product_ff}
                    >= {elapsed_ff, {QUO_BITS{1'b0}}});
         rem_ff <= CNT_W'(product_ff[PROD_W-1:QUO_BITS]);
         low_ff <= product_ff[QUO_BITS-1:0];
         quo_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= quo_bit ? CNT_W'(rem_shift - {1'b0, elapsed_ff}) : rem_shift[CNT_W-1:0];
         low_ff <= {low_ff[QUO_BITS-2:0], 1'b0};
         quo_ff <= {quo_ff[QUO_BITS-2:0], quo_bit};
      end
   end

   // Response snapshot register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_car_total         <= car_count_ff;
         rsp_phone_total       <= phone_count_ff;
         rsp_car_rate_tenths   <= car_rate_ff;
         rsp_phone_rate_tenths <= phone_rate_ff;
         rsp_recent_error      <= last_error_ff;
         rsp_repeat_count      <= error_repeats_ff;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/packet_traffic_rate_meter_top.sv
`default_nettype none
// Two-direction packet traffic meter.
// req_ch carries one event per transfer: forwarded packet (count toward car
// or phone), send failure (error number repeat tracking) or rate sample
// (millisecond timestamp). rsp_ch returns one status snapshot per event,
// taken after the event has been applied.
// Forwarded, failure, unused and zero-elapsed sample events skip the rate
// passes. A rate sample with time elapsed makes two passes (car, phone)
// through one shared multiplier and a 16-step restoring divider.
// One event is in work at a time; req_ch.ready is high while idle.
// The response register holds a finished snapshot while the receiver
// stalls; the next event is taken meanwhile and waits in the done step
// until the register frees.
// Synchronous reset clears all totals, marks, rates and the error record
// to zero and drops the response valid.
module packet_traffic_rate_meter_top
   import ptrm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   ptrm_req_if.sink  req_ch,
   ptrm_rsp_if.source rsp_ch
);

   ctl_cmd_type ctl_cmd;
   ctl_sts_type ctl_sts;

   ptrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (ctl_sts),
      .cmd       (ctl_cmd)
   );

   ptrm_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (ctl_cmd),
      .sts                   (ctl_sts),
      .req_command           (req_ch.command),
      .req_to_car            (req_ch.to_car),
      .req_error_code        (req_ch.error_code),
      .req_now_ms            (req_ch.now_ms),
      .rsp_car_total         (rsp_ch.car_total),
      .rsp_phone_total       (rsp_ch.phone_total),
      .rsp_car_rate_tenths   (rsp_ch.car_rate_tenths),
      .rsp_phone_rate_tenths (rsp_ch.phone_rate_tenths),
      .rsp_recent_error      (rsp_ch.recent_error),
      .rsp_repeat_count      (rsp_ch.repeat_count)
   );

endmodule
`default_nettype wire
